/* design/tcsc_pkg.sv */
// Shared constants and codes for the terrain cell speed classifier.
package tcsc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_BAND_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_WEIGHT_FORCE     = 3'd1;
    localparam logic [2:0] CFG_FORCE_THRESHOLD  = 3'd2;
    localparam logic [2:0] CFG_GROUND_CLEARANCE = 3'd3;
    localparam logic [2:0] CFG_CLASS_COUNT      = 3'd4;
    localparam logic [2:0] CFG_SLOPE_UNKNOWN    = 3'd5;
    localparam logic [2:0] CFG_STEP_UNKNOWN     = 3'd6;
    localparam logic [2:0] CFG_FORCE_UNKNOWN    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Cell kinds
    localparam logic [1:0] KIND_SPEED    = 2'd0;
    localparam logic [1:0] KIND_OBSTACLE = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd2;

    // Fixed class codes
    localparam logic [7:0] UNKNOWN_CODE  = 8'd0;
    localparam logic [7:0] OBSTACLE_CODE = 8'd1;
    localparam logic [7:0] CUSTOM_BASE   = 8'd2;

    // Angle reduction constants, Q3.12
    localparam logic [15:0] PI_Q12     = 16'd12868;
    localparam logic [15:0] TWO_PI_Q12 = 16'd25736;
    localparam logic [15:0] HALF_PI_Q12 = 16'd6434;

    // One in Q28
    localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

    // Taylor series divisors, innermost first
    localparam int unsigned DIV_C [0:3] = '{72, 42, 20, 6};

    // Pipeline stage numbers
    localparam int ST_F   = 18;
    localparam int ST_OUT = 28;

endpackage

/* design/terrain_cell_speed_classifier.sv */
// Top level of the terrain cell speed classifier pipeline.
//
// One map cell word is taken in every clock cycle (busy stays low) and its
// class word appears on o_class_code/o_cell_kind with o_valid; the receiver
// cannot stall. The pipeline holds the sine evaluation (four series terms,
// each a constant divide by reciprocal multiply, all but the innermost
// after a multiply) and the eight-stage restoring divider for the class.
// Configuration may only be written while no cell is in flight.
module terrain_cell_speed_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [15:0]                i_slope_angle,
    input  logic signed [31:0]                i_step_height,
    input  logic signed [31:0]                i_traction_force,
    input  logic                              i_cfg_we,
    input  logic [tcsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tcsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_valid,
    output logic [7:0]                        o_class_code,
    output logic [1:0]                        o_cell_kind
);
    import tcsc_pkg::*;

    // Configuration registers
    logic [2:0]  r_band_enable;
    logic [30:0] r_weight_force;
    logic [30:0] r_force_threshold;
    logic [30:0] r_ground_clearance;
    logic [7:0]  r_class_count;
    logic [15:0] r_slope_unknown;
    logic [31:0] r_step_unknown;
    logic [31:0] r_force_unknown;

    logic        w_accept;
    logic        w_has_slope;
    logic        w_has_step;
    logic        w_has_force;
    logic [30:0] w_thr;

    // Side information per stage
    logic        r_vld   [1:ST_OUT-1];
    logic [1:0]  r_kind  [1:ST_OUT-1];
    logic [31:0] r_force [1:ST_OUT-1];

    // Angle reduction
    logic [15:0] w_abs;
    logic [15:0] w_red;
    logic [15:0] w_fold;
    logic [1:0]  n_kind;
    logic [12:0] r_r;

    logic [29:0] r_x2;
    logic [12:0] r_r2;

    // Series units
    logic [29:0] r_ua_p   [0:3];
    logic [29:0] r_ua_x2  [0:3];
    logic [12:0] r_ua_r   [0:3];
    logic [59:0] r_ub_prod[0:3];
    logic [29:0] r_ub_p   [0:3];
    logic [29:0] r_ub_x2  [0:3];
    logic [12:0] r_ub_r   [0:3];
    logic [28:0] r_uc_t   [0:3];
    logic [29:0] r_uc_x2  [0:3];
    logic [12:0] r_uc_r   [0:3];

    // Sine, slope term and force
    logic [41:0] w_sin_mul;
    logic [28:0] r_sin;
    logic [44:0] r_pp_hi;
    logic [45:0] r_pp_lo;
    logic [60:0] w_term_sum;
    logic [32:0] r_term;
    logic signed [34:0] w_base;
    logic signed [34:0] w_f;
    logic signed [34:0] r_f;
    logic [30:0] w_m;

    // Divider
    logic [38:0] r_dv_rem [0:8];
    logic [7:0]  r_dv_q   [0:8];

    // Rounding
    logic        w_round_up;
    logic [8:0]  w_q9;
    logic [9:0]  w_code;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_has_slope = r_band_enable[0];
    assign w_has_step  = r_band_enable[1];
    assign w_has_force = r_band_enable[2];
    assign w_thr = (r_force_threshold == 31'd0) ? 31'd1 : r_force_threshold;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_enable      <= 3'd7;
            r_weight_force     <= 31'd0;
            r_force_threshold  <= 31'd256;
            r_ground_clearance <= 31'd0;
            r_class_count      <= 8'd1;
            r_slope_unknown    <= 16'h8000;
            r_step_unknown     <= 32'h8000_0000;
            r_force_unknown    <= 32'h8000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAND_ENABLE:      r_band_enable      <= i_cfg_data[2:0];
                CFG_WEIGHT_FORCE:     r_weight_force     <= i_cfg_data[30:0];
                CFG_FORCE_THRESHOLD:  r_force_threshold  <= i_cfg_data[30:0];
                CFG_GROUND_CLEARANCE: r_ground_clearance <= i_cfg_data[30:0];
                CFG_CLASS_COUNT:      r_class_count      <= i_cfg_data[7:0];
                CFG_SLOPE_UNKNOWN:    r_slope_unknown    <= i_cfg_data[15:0];
                CFG_STEP_UNKNOWN:     r_step_unknown     <= i_cfg_data;
                CFG_FORCE_UNKNOWN:    r_force_unknown    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify no-data and step obstacles, reduce the angle to [0, pi/2]
    always_comb begin
        w_abs = i_slope_angle[15] ? (~i_slope_angle + 16'd1) : i_slope_angle;
        if (w_abs >= TWO_PI_Q12) begin
            w_red = w_abs - TWO_PI_Q12;
        end else if (w_abs >= PI_Q12) begin
            w_red = w_abs - PI_Q12;
        end else begin
            w_red = w_abs;
        end
        w_fold = (w_red > HALF_PI_Q12) ? (PI_Q12 - w_red) : w_red;

        if ((w_has_slope && (i_slope_angle == r_slope_unknown)) ||
            (w_has_step && (i_step_height == r_step_unknown)) ||
            (w_has_force && (i_traction_force == r_force_unknown))) begin
            n_kind = KIND_UNKNOWN;
        end else if (w_has_step &&
                     (i_step_height > $signed({1'b0, r_ground_clearance}))) begin
            n_kind = KIND_OBSTACLE;
        end else begin
            n_kind = KIND_SPEED;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 1; n < ST_OUT; n++) begin
                r_vld[n] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else begin
            r_vld[1] <= w_accept;
            for (int n = 2; n < ST_OUT; n++) begin
                r_vld[n] <= r_vld[n-1];
            end
            o_valid <= r_vld[ST_OUT-1];
        end
    end

    // Advance side payload; the force stage may turn a cell into an obstacle
    always_ff @(posedge i_clk) begin
        r_kind[1]  <= n_kind;
        r_force[1] <= i_traction_force;
        for (int n = 2; n < ST_OUT; n++) begin
            r_force[n] <= r_force[n-1];
            if (n == ST_F) begin
                r_kind[n] <= ((r_kind[n-1] == KIND_SPEED) && (w_f <= 35'sd0))
                             ? KIND_OBSTACLE : r_kind[n-1];
            end else begin
                r_kind[n] <= r_kind[n-1];
            end
        end
    end

    // Square the reduced angle: x2 = (r << 16)^2 >> 28 = r^2 << 4
    always_ff @(posedge i_clk) begin
        r_r  <= w_fold[12:0];
        r_x2 <= {(26'(r_r) * 26'(r_r)), 4'b0000};
        r_r2 <= r_r;
    end

    // Series terms: t = 1 - ((x2 * t) >> 28) / c, innermost uses x2 alone
    for (genvar j = 0; j < 4; j++) begin : g_term
        localparam logic [59:0] MUL_K = 60'((64'd1 << 32) / DIV_C[j]);
        localparam logic [30:0] CK    = 31'(DIV_C[j]);

        logic [29:0] w_p;
        logic [29:0] w_x2_in;
        logic [12:0] w_r_in;
        logic [27:0] w_q_est;
        logic [30:0] w_chk;
        logic [27:0] w_q;

        if (j == 0) begin : g_first
            assign w_p     = r_x2;
            assign w_x2_in = r_x2;
            assign w_r_in  = r_r2;
        end else begin : g_next
            logic [58:0] w_mul;
            assign w_mul   = 59'(r_uc_x2[j-1]) * 59'(r_uc_t[j-1]);
            assign w_p     = w_mul[57:28];
            assign w_x2_in = r_uc_x2[j-1];
            assign w_r_in  = r_uc_r[j-1];
        end

        // Correct the reciprocal estimate by at most one
        assign w_q_est = r_ub_prod[j][59:32];
        assign w_chk   = 31'(r_ub_p[j]) - (31'(w_q_est) * CK);
        assign w_q     = (w_chk >= CK) ? (w_q_est + 28'd1) : w_q_est;

        always_ff @(posedge i_clk) begin
            r_ua_p[j]    <= w_p;
            r_ua_x2[j]   <= w_x2_in;
            r_ua_r[j]    <= w_r_in;
            r_ub_prod[j] <= 60'(r_ua_p[j]) * MUL_K;
            r_ub_p[j]    <= r_ua_p[j];
            r_ub_x2[j]   <= r_ua_x2[j];
            r_ub_r[j]    <= r_ua_r[j];
            r_uc_t[j]    <= ONE_Q28 - 29'(w_q);
            r_uc_x2[j]   <= r_ub_x2[j];
            r_uc_r[j]    <= r_ub_r[j];
        end
    end

    // Sine, slope term in two partial products, then usable force
    assign w_sin_mul  = 42'(r_uc_r[3]) * 42'(r_uc_t[3]);
    assign w_term_sum = {r_pp_hi[44:0], 15'b0} + 61'(r_pp_lo) + 61'h800_0000;

    always_comb begin
        w_base = w_has_force ? 35'(signed'(r_force[ST_F-1]))
                             : $signed({4'b0000, w_thr});
        w_f    = w_has_slope ? (w_base - $signed({2'b00, r_term})) : w_base;
        w_m    = (r_f[33:0] < 34'(w_thr)) ? r_f[30:0] : w_thr;
    end

    always_ff @(posedge i_clk) begin
        r_sin   <= w_sin_mul[40:12];
        r_pp_hi <= 45'(r_weight_force) * 45'(r_sin[28:15]);
        r_pp_lo <= 46'(r_weight_force) * 46'(r_sin[14:0]);
        r_term  <= w_term_sum[60:28];
        r_f     <= w_f;
        r_dv_rem[0] <= 39'(r_class_count) * 39'(w_m);
        r_dv_q[0]   <= 8'd0;
    end

    // Restoring divide by the threshold, one quotient bit per stage
    for (genvar i = 1; i <= 8; i++) begin : g_div
        logic [38:0] w_dsh;
        logic        w_ge;
        assign w_dsh = 39'(w_thr) << (8 - i);
        assign w_ge  = (r_dv_rem[i-1] >= w_dsh);
        always_ff @(posedge i_clk) begin
            r_dv_rem[i] <= w_ge ? (r_dv_rem[i-1] - w_dsh) : r_dv_rem[i-1];
            r_dv_q[i]   <= {r_dv_q[i-1][6:0], w_ge};
        end
    end

    // Round half to even, add the base and saturate
    always_comb begin
        w_round_up = ({r_dv_rem[8], 1'b0} > 40'(w_thr)) ||
                     (({r_dv_rem[8], 1'b0} == 40'(w_thr)) && r_dv_q[8][0]);
        w_q9   = 9'(r_dv_q[8]) + {8'd0, w_round_up};
        w_code = 10'(CUSTOM_BASE) + 10'(w_q9);
    end

    // Drive the result word
    always_ff @(posedge i_clk) begin
        o_cell_kind <= r_kind[ST_OUT-1];
        case (r_kind[ST_OUT-1])
            KIND_UNKNOWN:  o_class_code <= UNKNOWN_CODE;
            KIND_OBSTACLE: o_class_code <= OBSTACLE_CODE;
            default:       o_class_code <= (w_code > 10'd255) ? 8'd255 : w_code[7:0];
        endcase
    end

    // A result word always traces back to a start word
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, ST_OUT))
        else $error("result word without matching start");

    a_unknown_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_cell_kind == KIND_UNKNOWN)) |-> (o_class_code == UNKNOWN_CODE))
        else $error("unknown cell with wrong code");

    a_speed_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_cell_kind == KIND_SPEED)) |-> (o_class_code >= CUSTOM_BASE))
        else $error("speed class below custom base");

endmodule
